### sv/mm3h_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// mm3h_pkg
// Shared constants, types and helpers of the streaming MurmurHash3 x86_32 unit.
// -----------------------------------------------------------------------------
package mm3h_pkg;

   // mixing constants
   localparam logic [31:0] MM_C1         = 32'hcc9e2d51;
   localparam logic [31:0] MM_C2         = 32'h1b873593;
   localparam logic [31:0] MM_ADD        = 32'he6546b64;
   localparam logic [31:0] MM_F1         = 32'h85ebca6b;
   localparam logic [31:0] MM_F2         = 32'hc2b2ae35;
   localparam logic [31:0] MM_SEED_RESET = 32'd192837465;
   localparam int          MM_K_ROT      = 15;
   localparam int          MM_H_ROT      = 13;

   // byte counts
   localparam logic [2:0]  WORD_BYTES    = 3'd4;
   localparam logic [2:0]  NO_BYTES      = 3'd0;

   // operand selection of the shared multiplier
   typedef enum logic [1:0] {
      MUL_SCR1 = 2'd0,   // data word times C1
      MUL_SCR2 = 2'd1,   // rotated product times C2
      MUL_FIN1 = 2'd2,   // folded hash times F1
      MUL_FIN2 = 2'd3    // shifted product times F2
   } mul_sel_type;

   // commands from controller to datapath
   typedef struct packed {
      logic        load_item;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        mix_full;
      logic        mix_tail;
      logic        hash_restart;
      logic        out_load;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic item_last;
      logic item_full;
      logic item_empty;
   } status_type;

   // rotate left by a constant amount
   function automatic logic [31:0] rotl32(input logic [31:0] v, input int r);
      logic [31:0] res;
      res = (v << r) | (v >> (32 - r));
      return res;
   endfunction

endpackage

### sv/murmur3_32_stream_hash_unit.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// murmur3_32_stream_hash_unit
// Streaming MurmurHash3 x86_32 of a byte message, one 32-bit word per
// transaction, with a configurable seed.
// -----------------------------------------------------------------------------
// One input word is taken at a time and a single 32x32 multiplier is shared by
// all mixing steps, one product per cycle. A non-last word goes through accept,
// two scramble products and the hash mix. A last item with 1 to 4 bytes goes
// through those steps plus two finalization products and the result load; an
// empty last item goes through accept, one skipped scramble step, two
// finalization products and the result load. The result
// sits in an output register, so the next message is accepted while a hash
// waits to be taken; a second result waits in the last step until that
// register frees up. Writing the seed reloads the running hash and clears the
// length, so a message in progress restarts.
// -----------------------------------------------------------------------------
module murmur3_32_stream_hash_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_data_word,
   input  logic [2:0]  req_byte_count,
   input  logic        req_last_item,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_hash_value,
   input  logic        csr_write_en,
   input  logic [31:0] csr_write_data
);
   import mm3h_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencer
   mm3h_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // hashing datapath
   mm3h_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_data_word  (req_data_word),
      .req_byte_count (req_byte_count),
      .req_last_item  (req_last_item),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .cmd            (cmd),
      .status         (status),
      .rsp_hash_value (rsp_hash_value)
   );

`ifndef SYNTHESIS
   // unit is busy right after taking a transaction
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("unit not busy after accepting a transaction");

   // a new hash never overwrites one still waiting
   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid || !rsp_stall))
      else $error("result register overwritten while stalled");

   // a loaded hash is offered on the next cycle
   a_result_offered: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid)
      else $error("loaded result not offered");

   // multiplier and hash mix never share a cycle
   a_mix_after_product: assert property (@(posedge clock) disable iff (reset)
      (cmd.mix_full || cmd.mix_tail) |-> !cmd.mul_en && $past(cmd.mul_en))
      else $error("hash mix without a preceding product");
`endif

endmodule

### sv/mm3h_datapath.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// mm3h_datapath
// Item registers, shared 32x32 multiplier, running hash, byte length and
// result register of the MurmurHash3 unit.
// -----------------------------------------------------------------------------
module mm3h_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [31:0]          req_data_word,
   input  logic [2:0]           req_byte_count,
   input  logic                 req_last_item,
   input  logic                 csr_write_en,
   input  logic [31:0]          csr_write_data,
   input  mm3h_pkg::cmd_type    cmd,
   output mm3h_pkg::status_type status,
   output logic [31:0]          rsp_hash_value
);
   import mm3h_pkg::*;

   logic [31:0] seed_ff, seed_in;
   logic [31:0] hash_ff, hash_in;
   logic [31:0] len_ff, len_in;
   logic [31:0] word_ff, word_in;
   logic [2:0]  count_ff, count_in;
   logic        last_ff, last_in;
   logic [31:0] prod_ff, prod_in;
   logic [31:0] out_ff, out_in;

   logic [2:0]  count_sat;
   logic [31:0] byte_mask;
   logic [31:0] mul_a, mul_b, mul_p;
   logic [31:0] fold;
   logic [31:0] mixed;

   // byte count: taken as four except on the last item, saturated at four
   always_comb begin
      if (!req_last_item || req_byte_count > WORD_BYTES) begin
         count_sat = WORD_BYTES;
      end else begin
         count_sat = req_byte_count;
      end
   end

   // keep only the valid low bytes
   always_comb begin
      case (count_sat)
         3'd0:    byte_mask = 32'h0000_0000;
         3'd1:    byte_mask = 32'h0000_00ff;
         3'd2:    byte_mask = 32'h0000_ffff;
         3'd3:    byte_mask = 32'h00ff_ffff;
         default: byte_mask = 32'hffff_ffff;
      endcase
   end

   // length folded in and upper half xored down
   always_comb begin
      fold = hash_ff ^ len_ff;
      fold = fold ^ (fold >> 16);
   end

   // shared multiplier operands
   always_comb begin
      case (cmd.mul_sel)
         MUL_SCR1: begin
            mul_a = word_ff;
            mul_b = MM_C1;
         end
         MUL_SCR2: begin
            mul_a = rotl32(prod_ff, MM_K_ROT);
            mul_b = MM_C2;
         end
         MUL_FIN1: begin
            mul_a = fold;
            mul_b = MM_F1;
         end
         MUL_FIN2: begin
            mul_a = prod_ff ^ (prod_ff >> 13);
            mul_b = MM_F2;
         end
         default: begin
            mul_a = word_ff;
            mul_b = MM_C1;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // block mix: rotate, times five plus constant
   always_comb begin
      mixed = rotl32(hash_ff ^ prod_ff, MM_H_ROT);
      mixed = (mixed << 2) + mixed + MM_ADD;
   end

   // next state of the datapath registers
   always_comb begin
      seed_in  = seed_ff;
      hash_in  = hash_ff;
      len_in   = len_ff;
      word_in  = word_ff;
      count_in = count_ff;
      last_in  = last_ff;
      prod_in  = prod_ff;
      out_in   = out_ff;
      if (cmd.load_item) begin
         word_in  = req_data_word & byte_mask;
         count_in = count_sat;
         last_in  = req_last_item;
      end
      if (cmd.mul_en) begin
         prod_in = mul_p;
      end
      if (cmd.mix_full) begin
         hash_in = mixed;
         len_in  = len_ff + 32'(WORD_BYTES);
      end
      if (cmd.mix_tail) begin
         hash_in = hash_ff ^ prod_ff;
         len_in  = len_ff + 32'(count_ff);
      end
      if (cmd.hash_restart) begin
         hash_in = seed_ff;
         len_in  = '0;
      end
      if (cmd.out_load) begin
         out_in = prod_ff ^ (prod_ff >> 16);
      end
      // seed write restarts any message
      if (csr_write_en) begin
         seed_in = csr_write_data;
         hash_in = csr_write_data;
         len_in  = '0;
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= MM_SEED_RESET;
         hash_ff <= MM_SEED_RESET;
         len_ff  <= '0;
      end else begin
         seed_ff <= seed_in;
         hash_ff <= hash_in;
         len_ff  <= len_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      word_ff  <= word_in;
      count_ff <= count_in;
      last_ff  <= last_in;
      prod_ff  <= prod_in;
      out_ff   <= out_in;
   end

   assign status.item_last  = last_ff;
   assign status.item_full  = (count_ff == WORD_BYTES);
   assign status.item_empty = (count_ff == NO_BYTES);
   assign rsp_hash_value    = out_ff;

endmodule

### sv/mm3h_ctrl.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// mm3h_ctrl
// Sequencer of the MurmurHash3 unit: steps each item through scramble, mix
// and finalization, and owns the input and result handshakes.
// -----------------------------------------------------------------------------
module mm3h_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  mm3h_pkg::status_type status,
   output mm3h_pkg::cmd_type    cmd
);
   import mm3h_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_SCR1 = 7'b0000010,
      ST_SCR2 = 7'b0000100,
      ST_MIX  = 7'b0001000,
      ST_FIN1 = 7'b0010000,
      ST_FIN2 = 7'b0100000,
      ST_DONE = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.mul_sel = MUL_SCR1;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_SCR1;
            end
         end
         ST_SCR1: begin
            // empty last item skips straight to finalization
            if (status.item_empty) begin
               state_in = ST_FIN1;
            end else begin
               cmd.mul_en  = 1'b1;
               cmd.mul_sel = MUL_SCR1;
               state_in    = ST_SCR2;
            end
         end
         ST_SCR2: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_SCR2;
            state_in    = ST_MIX;
         end
         ST_MIX: begin
            cmd.mix_full = status.item_full;
            cmd.mix_tail = !status.item_full;
            state_in     = status.item_last ? ST_FIN1 : ST_IDLE;
         end
         ST_FIN1: begin
            cmd.mul_en       = 1'b1;
            cmd.mul_sel      = MUL_FIN1;
            cmd.hash_restart = 1'b1;
            state_in         = ST_FIN2;
         end
         ST_FIN2: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_FIN2;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            // wait for the result register to be free
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result valid: set on load, cleared when the transaction completes
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// testbench
// Self-checking bench for the streaming MurmurHash3 x86_32 unit. A short
// table of directed messages covers the byte count extremes, tail masking,
// ignored counts on inner words and seed changes. It is followed by random
// messages under several seeds. Every accepted word goes through a local hash
// model, and each returned hash is compared with the oldest predicted one.
// Both channels idle at random; one phase runs without idling, one holds the
// result side off long enough to back up the input.
// -----------------------------------------------------------------------------
module testbench;
   import mm3h_pkg::*;

   localparam int CLOCK_PERIOD    = 20;
   localparam int RESET_CYCLES    = 8;
   localparam int SETTLE_CYCLES   = 12;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int NUM_PHASES      = 8;
   localparam int PHASE_ITEMS     = 150;
   localparam int MAX_REPORTS     = 10;
   localparam int NUM_ROWS        = 20;

   // one directed transaction, with an optional seed load in front of it
   typedef struct packed {
      logic        seed_write;
      logic [31:0] seed_value;
      logic [31:0] word;
      logic [2:0]  count;
      logic        last;
      logic        known;
      logic [31:0] known_hash;
   } directed_row_type;

   localparam directed_row_type DIRECTED_ROWS [NUM_ROWS] = '{
      // empty message with the reset seed
      '{1'b0, 32'h0, 32'h0000_0000, NO_BYTES, 1'b1, 1'b0, 32'h0},
      // full word as last item, then count above four saturating
      '{1'b0, 32'h0, 32'hffff_ffff, WORD_BYTES, 1'b1, 1'b0, 32'h0},
      '{1'b0, 32'h0, 32'hffff_ffff, 3'd7, 1'b1, 1'b0, 32'h0},
      '{1'b0, 32'h0, 32'h1234_5678, 3'd5, 1'b1, 1'b0, 32'h0},
      // one to three byte tails, upper bytes must be masked off
      '{1'b0, 32'h0, 32'ha5a5_a5a5, 3'd1, 1'b1, 1'b0, 32'h0},
      '{1'b0, 32'h0, 32'hffff_ffff, 3'd2, 1'b1, 1'b0, 32'h0},
      '{1'b0, 32'h0, 32'hdead_beef, 3'd3, 1'b1, 1'b0, 32'h0},
      // inner words with counts other than four are taken as full words
      '{1'b0, 32'h0, 32'h0000_0000, NO_BYTES, 1'b0, 1'b0, 32'h0},
      '{1'b0, 32'h0, 32'hffff_ffff, 3'd2, 1'b0, 1'b0, 32'h0},
      '{1'b0, 32'h0, 32'h8000_0001, 3'd6, 1'b0, 1'b0, 32'h0},
      '{1'b0, 32'h0, 32'h7fff_ffff, 3'd3, 1'b1, 1'b0, 32'h0},
      // zero seed: the empty message hashes to zero
      '{1'b1, 32'h0000_0000, 32'h0000_0000, NO_BYTES, 1'b1, 1'b1, 32'h0000_0000},
      '{1'b0, 32'h0, 32'h0000_0000, WORD_BYTES, 1'b1, 1'b0, 32'h0},
      '{1'b0, 32'h0, 32'h0000_0061, 3'd1, 1'b1, 1'b0, 32'h0},
      // all-ones seed
      '{1'b1, 32'hffff_ffff, 32'h0000_0000, NO_BYTES, 1'b1, 1'b0, 32'h0},
      '{1'b0, 32'h0, 32'hffff_ffff, WORD_BYTES, 1'b0, 1'b0, 32'h0},
      '{1'b0, 32'h0, 32'h0f0f_0f0f, 3'd4, 1'b0, 1'b0, 32'h0},
      '{1'b0, 32'h0, 32'hffff_ffff, 3'd6, 1'b1, 1'b0, 32'h0},
      // back to the reset seed, inner word then empty last item
      '{1'b1, MM_SEED_RESET, 32'h6c6c_6548, WORD_BYTES, 1'b0, 1'b0, 32'h0},
      '{1'b0, 32'h0, 32'h0000_0000, NO_BYTES, 1'b1, 1'b0, 32'h0}
   };

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [31:0] req_data_word;
   logic [2:0]  req_byte_count;
   logic        req_last_item;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_hash_value;
   logic        csr_write_en;
   logic [31:0] csr_write_data;

   // hash model state
   logic [31:0] seed_reg;
   logic [31:0] run_hash;
   logic [31:0] byte_total;
   logic [31:0] pending_hashes [$];

   logic [31:0] hash_want;
   int          fail_count;
   bit          send_idle_on;
   bit          recv_idle_on;
   bit          hold_off_req;

   murmur3_32_stream_hash_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_word  (req_data_word),
      .req_byte_count (req_byte_count),
      .req_last_item  (req_last_item),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hash_value (rsp_hash_value),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   // clock and reset
   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   initial begin
      reset <= 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
   end

   // run limit
   initial begin
      #5_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   // key scramble: multiply, rotate left 15, multiply
   function automatic logic [31:0] scramble_key(input logic [31:0] k);
      logic [31:0] t;
      t = k * MM_C1;
      t = {t[16:0], t[31:17]};
      t = t * MM_C2;
      return t;
   endfunction

   // final avalanche of the folded hash
   function automatic logic [31:0] avalanche_mix(input logic [31:0] h);
      logic [31:0] t;
      t = h ^ (h >> 16);
      t = t * MM_F1;
      t = t ^ (t >> 13);
      t = t * MM_F2;
      t = t ^ (t >> 16);
      return t;
   endfunction

   // advance the hash model by one word, returns 1 when a hash comes out
   function automatic bit hash_predict_item(input logic [31:0] word, input logic [2:0] count,
                                            input logic last, output logic [31:0] hash);
      logic [31:0] h;
      logic [31:0] mask;
      hash = 32'h0;
      if (!last || count >= WORD_BYTES) begin
         h = run_hash ^ scramble_key(word);
         h = {h[18:0], h[31:19]};
         run_hash = h * 32'd5 + MM_ADD;
         byte_total = byte_total + 32'd4;
      end else if (count != NO_BYTES) begin
         mask = (32'h1 << (8 * count)) - 32'h1;
         run_hash = run_hash ^ scramble_key(word & mask);
         byte_total = byte_total + 32'(count);
      end
      if (!last) return 1'b0;
      hash = avalanche_mix(run_hash ^ byte_total);
      run_hash = seed_reg;
      byte_total = 32'h0;
      return 1'b1;
   endfunction

   task automatic report_failure(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
      fail_count++;
      if (fail_count <= MAX_REPORTS)
         $display("%0t: %s: expected %08h actual %08h", $time, what, want, got);
   endtask

   // offer one transaction and wait for it to be taken
   task automatic send_item(input logic [31:0] word, input logic [2:0] count,
                            input logic last, input logic known,
                            input logic [31:0] known_hash);
      logic [31:0] hash;
      if (send_idle_on) begin
         while ($urandom_range(99) < 12) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid      <= 1'b1;
      req_data_word  <= word;
      req_byte_count <= count;
      req_last_item  <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (hash_predict_item(word, count, last, hash))
         pending_hashes.push_back(known ? known_hash : hash);
   endtask

   // stop offering and wait for every predicted hash
   task automatic wait_hashes_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_hashes.size() != 0) @(posedge clock);
   endtask

   // seed load while the unit is idle
   task automatic load_seed(input logic [31:0] value);
      wait_hashes_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      seed_reg   = value;
      run_hash   = value;
      byte_total = 32'h0;
   endtask

   // one random message, returns the number of words sent
   task automatic send_random_message(output int words);
      logic [2:0] count;
      words = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
      for (int i = 0; i < words - 1; i++) begin
         count = ($urandom_range(3) == 0) ? 3'($urandom_range(7)) : WORD_BYTES;
         send_item($urandom, count, 1'b0, 1'b0, 32'h0);
      end
      count = 3'($urandom_range(7));
      send_item($urandom, count, 1'b1, 1'b0, 32'h0);
   endtask

   // result side: random stall, with a long hold-off on request
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else begin
            rsp_stall <= recv_idle_on && ($urandom_range(99) < 12);
         end
      end
   end

   // compare each returned hash with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_hashes.size() == 0) begin
            report_failure("hash with none pending", 32'h0, rsp_hash_value);
         end else begin
            hash_want = pending_hashes.pop_front();
            if (rsp_hash_value !== hash_want)
               report_failure("hash_value mismatch", hash_want, rsp_hash_value);
         end
      end
   end

   // stimulus
   initial begin
      int sent;
      int words;
      fail_count     = 0;
      send_idle_on   = 1'b1;
      recv_idle_on   = 1'b1;
      hold_off_req   = 1'b0;
      seed_reg       = MM_SEED_RESET;
      run_hash       = MM_SEED_RESET;
      byte_total     = 32'h0;
      req_valid      <= 1'b0;
      req_data_word  <= 32'h0;
      req_byte_count <= NO_BYTES;
      req_last_item  <= 1'b0;
      csr_write_en   <= 1'b0;
      csr_write_data <= 32'h0;
      @(posedge clock);
      while (reset) @(posedge clock);

      // directed table
      for (int r = 0; r < NUM_ROWS; r++) begin
         if (DIRECTED_ROWS[r].seed_write) load_seed(DIRECTED_ROWS[r].seed_value);
         send_item(DIRECTED_ROWS[r].word, DIRECTED_ROWS[r].count, DIRECTED_ROWS[r].last,
                   DIRECTED_ROWS[r].known, DIRECTED_ROWS[r].known_hash);
      end

      // random messages, a new seed per phase
      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0:       load_seed(32'hffff_ffff);
            1:       load_seed(32'h0000_0000);
            default: load_seed($urandom);
         endcase
         send_idle_on = (p != 2);
         recv_idle_on = (p != 2);
         if (p == 4) hold_off_req = 1'b1;
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            send_random_message(words);
            sent += words;
            // sender pause mid phase until all hashes are back
            if (p == 5 && sent >= PHASE_ITEMS / 2 && sent - words < PHASE_ITEMS / 2)
               wait_hashes_drained();
         end
      end

      wait_hashes_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_hashes.size() != 0) begin
         fail_count += pending_hashes.size();
         $display("%0d predicted hashes never delivered", pending_hashes.size());
      end
      if (fail_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
